// File: rtl/prl_pkg.sv
package prl_pkg;

  // Field widths, fixed by the item format
  localparam int COORD_BITS = 24;
  localparam int OP_W       = 2;
  localparam int RIDX_W     = 4;
  localparam int VIDX_W     = 5;
  localparam int VCNT_W     = 6;
  localparam int CFG_W      = 5;
  localparam int HIT_W      = 4;

  // Default table dimensions
  localparam int DEF_MAX_REGIONS  = 16;
  localparam int DEF_MAX_VERTICES = 32;

  // Cycles from a vertex read to the inside flag being updated, minus one
  localparam int PIPE_LAT = 3;
  localparam int DRN_W    = $clog2(PIPE_LAT + 1);

  // Opcodes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]              opcode;
    logic [RIDX_W-1:0]            region_index;
    logic [VIDX_W-1:0]            vertex_index;
    logic [VCNT_W-1:0]            vertex_count;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [HIT_W-1:0]  hit_region;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_vertex;
    logic load_count;
    logic load_query;
    logic rd_en;
    logic rd_edge;
    logic clear_inside;
  } cmd_t;

endpackage

// File: rtl/polygon_region_lookup_unit.sv
// Point-in-region lookup over a table of polygons (even-odd ray casting).
// Request channel: req_valid / req_stall with a prl_pkg::req_t payload.
//   Opcode write vertex and set count give no response.
//   Opcode query searches regions 0 .. regions_in_use-1 and gives exactly
//   one response; the unused opcode is dropped.
// Response channel: rsp_valid / rsp_stall with a prl_pkg::rsp_t payload.
// Configuration: cfg_valid / cfg_ready carries regions_in_use; always ready.
// Query: regions without vertices are skipped; each searched region is walked
//   vertex by vertex, then the pipeline drains before the flag is read. One
//   vertex is read per cycle from the single-port vertex RAM; one query is in
//   flight at a time and req_stall is high while it runs.
// A finished response waits in an output register, so further writes are
//   taken while the receiver stalls; a following query holds at its end
//   until the register is free.
// Reset clears the vertex counts and regions_in_use; vertex coordinates are
//   undefined until written.
module polygon_region_lookup_unit #(
  parameter int MAX_REGIONS  = prl_pkg::DEF_MAX_REGIONS,
  parameter int MAX_VERTICES = prl_pkg::DEF_MAX_VERTICES,
  localparam int REG_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
  localparam int VTX_W  = $clog2(MAX_VERTICES),
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  prl_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output prl_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [prl_pkg::CFG_W-1:0] cfg_data
);

  import prl_pkg::*;

  cmd_t             cmd;
  logic [REG_W-1:0] region_sel;
  logic [VTX_W-1:0] vertex_sel;
  logic [CNT_W-1:0] region_count;
  logic             in_region;

  prl_ctrl #(
    .MAX_REGIONS  (MAX_REGIONS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .opcode       (req.opcode),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .region_sel   (region_sel),
    .vertex_sel   (vertex_sel),
    .region_count (region_count),
    .in_region    (in_region)
  );

  prl_datapath #(
    .MAX_REGIONS  (MAX_REGIONS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cmd          (cmd),
    .region_sel   (region_sel),
    .vertex_sel   (vertex_sel),
    .region_count (region_count),
    .in_region    (in_region)
  );

  // A walk read never shares the RAM port or count table with a load
  a_no_load_during_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !cmd.load_vertex && !cmd.load_count)
    else $error("table load issued during a region walk");

  // An accepted query blocks further requests
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.opcode == OP_QUERY) |=> req_stall)
    else $error("request accepted while a query is running");

  // A response appears only at the end of a running query
  a_rsp_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response raised without a running query");

  // Not-found reports region zero
  a_miss_region_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |-> rsp.hit_region == '0)
    else $error("miss carries a non-zero region");

endmodule

// File: rtl/prl_ram.sv
module prl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/prl_datapath.sv
module prl_datapath #(
  parameter int MAX_REGIONS  = prl_pkg::DEF_MAX_REGIONS,
  parameter int MAX_VERTICES = prl_pkg::DEF_MAX_VERTICES,
  localparam int REG_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
  localparam int VTX_W  = $clog2(MAX_VERTICES),
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  prl_pkg::req_t     req,
  input  prl_pkg::cmd_t     cmd,
  input  logic [REG_W-1:0]  region_sel,
  input  logic [VTX_W-1:0]  vertex_sel,
  output logic [CNT_W-1:0]  region_count,
  output logic              in_region
);

  import prl_pkg::*;

  localparam int DEPTH  = MAX_REGIONS * MAX_VERTICES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CB     = COORD_BITS;

  logic [CNT_W-1:0]      counts [MAX_REGIONS];
  logic [CNT_W-1:0]      count_sat;
  logic                  region_ok;
  logic                  wr_ok;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     ram_addr;
  logic                  ram_we;
  logic [2*CB-1:0]       ram_rdata;

  logic signed [CB-1:0]  px, py;
  logic signed [CB-1:0]  ax, ay, bx, by;
  logic signed [CB-1:0]  last_x, last_y;
  logic                  v1, e1;
  logic                  straddle;

  logic                  s2_valid;
  logic signed [CB:0]    s2_dxp, s2_dy, s2_dxb, s2_dyp;
  logic                  s3_valid;
  logic                  s3_pos;
  logic signed [2*CB+1:0] s3_lhs, s3_rhs;
  logic                  hit;

  // Address decode for writes and walk reads
  assign region_ok = int'(req.region_index) < MAX_REGIONS;
  assign wr_ok     = region_ok && (int'(req.vertex_index) < MAX_VERTICES);
  assign wr_addr   = ADDR_W'(ADDR_W'(req.region_index) * ADDR_W'(MAX_VERTICES)
                     + ADDR_W'(req.vertex_index));
  assign rd_addr   = ADDR_W'(ADDR_W'(region_sel) * ADDR_W'(MAX_VERTICES)
                     + ADDR_W'(vertex_sel));
  assign ram_we    = cmd.load_vertex && wr_ok;
  assign ram_addr  = cmd.load_vertex ? wr_addr : rd_addr;

  prl_ram #(
    .WIDTH (2 * CB),
    .DEPTH (DEPTH)
  ) u_vertex_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({req.coord_x, req.coord_y}),
    .rdata (ram_rdata)
  );

  // Saturate the vertex count to the table depth
  always_comb begin
    if (int'(req.vertex_count) > MAX_VERTICES) begin
      count_sat = CNT_W'(MAX_VERTICES);
    end else begin
      count_sat = CNT_W'(req.vertex_count);
    end
  end

  // Region vertex counts, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_REGIONS; r++) begin
        counts[r] <= '0;
      end
    end else if (cmd.load_count && region_ok) begin
      counts[REG_W'(req.region_index)] <= count_sat;
    end
  end

  assign region_count = (int'(region_sel) < MAX_REGIONS) ? counts[region_sel] : '0;

  // Current vertex from the RAM, previous vertex from the last read
  assign ax = ram_rdata[2*CB-1:CB];
  assign ay = ram_rdata[CB-1:0];
  assign bx = last_x;
  assign by = last_y;
  assign straddle = (ay > py) != (by > py);

  // Crossing lies right of the point; flip the sense for a falling edge
  assign hit = s3_pos ? (s3_lhs < s3_rhs) : (s3_rhs < s3_lhs);

  // Pipeline control and inside flag
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      e1        <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      in_region <= 1'b0;
    end else begin
      v1       <= cmd.rd_en;
      e1       <= cmd.rd_edge;
      s2_valid <= v1 && e1 && straddle;
      s3_valid <= s2_valid;
      if (cmd.clear_inside) begin
        in_region <= 1'b0;
      end else if (s3_valid && hit) begin
        in_region <= ~in_region;
      end
    end
  end

  // Pipeline payload: differences, then products
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      px <= req.coord_x;
      py <= req.coord_y;
    end
    if (v1) begin
      last_x <= ax;
      last_y <= ay;
    end
    s2_dxp <= (CB+1)'(px) - (CB+1)'(ax);
    s2_dy  <= (CB+1)'(by) - (CB+1)'(ay);
    s2_dxb <= (CB+1)'(bx) - (CB+1)'(ax);
    s2_dyp <= (CB+1)'(py) - (CB+1)'(ay);
    s3_lhs <= s2_dxp * s2_dy;
    s3_rhs <= s2_dxb * s2_dyp;
    s3_pos <= ~s2_dy[CB];
  end

endmodule

// File: rtl/prl_ctrl.sv
module prl_ctrl #(
  parameter int MAX_REGIONS  = prl_pkg::DEF_MAX_REGIONS,
  parameter int MAX_VERTICES = prl_pkg::DEF_MAX_VERTICES,
  localparam int REG_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
  localparam int VTX_W  = $clog2(MAX_VERTICES),
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [prl_pkg::OP_W-1:0]  opcode,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output prl_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [prl_pkg::CFG_W-1:0] cfg_data,
  output prl_pkg::cmd_t             cmd,
  output logic [REG_W-1:0]          region_sel,
  output logic [VTX_W-1:0]          vertex_sel,
  input  logic [CNT_W-1:0]          region_count,
  input  logic                      in_region
);

  import prl_pkg::*;

  localparam int RCNT_W = $clog2(MAX_REGIONS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REGION = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]        state, state_next;
  logic [CFG_W-1:0]  regions_in_use;
  logic [RCNT_W-1:0] region;
  logic [RCNT_W-1:0] limit;
  logic [VTX_W-1:0]  vcnt;
  logic [VTX_W-1:0]  last_vtx;
  logic [DRN_W-1:0]  drain_cnt;
  logic              drain_done;
  logic              found_q;
  logic              accept;
  logic              rsp_load;
  logic              region_live;

  assign cfg_ready   = 1'b1;
  assign req_stall   = (state != S_IDLE);
  assign accept      = req_valid && !req_stall;
  assign last_vtx    = VTX_W'(region_count - 1'b1);
  assign drain_done  = (drain_cnt == DRN_W'(PIPE_LAT));
  assign region_live = (region < limit);
  assign rsp_load    = (state == S_FINISH) && (!rsp_valid || !rsp_stall);
  assign region_sel  = REG_W'(region);
  assign vertex_sel  = (state == S_REGION) ? last_vtx : vcnt;

  // Clamp the search range to the table size
  always_comb begin
    if (int'(regions_in_use) > MAX_REGIONS) begin
      limit = RCNT_W'(MAX_REGIONS);
    end else begin
      limit = RCNT_W'(regions_in_use);
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_WRITE: cmd.load_vertex = 1'b1;
            OP_COUNT: cmd.load_count  = 1'b1;
            OP_QUERY: begin
              cmd.load_query = 1'b1;
              state_next     = S_REGION;
            end
            default: ;
          endcase
        end
      end
      S_REGION: begin
        if (!region_live) begin
          state_next = S_FINISH;
        end else if (region_count != '0) begin
          // Prime with the last vertex, which closes the boundary
          cmd.rd_en        = 1'b1;
          cmd.clear_inside = 1'b1;
          state_next       = S_WALK;
        end
      end
      S_WALK: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_edge = 1'b1;
        if (vcnt == last_vtx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_done) begin
          state_next = in_region ? S_FINISH : S_REGION;
        end
      end
      S_FINISH: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, counters and result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      regions_in_use <= '0;
      region         <= '0;
      vcnt           <= '0;
      drain_cnt      <= '0;
      found_q        <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        regions_in_use <= cfg_data;
      end
      if (state == S_IDLE && accept) begin
        region  <= '0;
        found_q <= 1'b0;
      end
      if (state == S_REGION) begin
        vcnt      <= '0;
        drain_cnt <= '0;
        if (region_live && region_count == '0) begin
          region <= region + 1'b1;
        end
      end
      if (state == S_WALK) begin
        vcnt <= vcnt + 1'b1;
      end
      if (state == S_DRAIN) begin
        drain_cnt <= drain_cnt + 1'b1;
        if (drain_done) begin
          if (in_region) begin
            found_q <= 1'b1;
          end else begin
            region <= region + 1'b1;
          end
        end
      end
      // Hold the result until taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.found      <= found_q;
      rsp.hit_region <= found_q ? HIT_W'(region) : '0;
    end
  end

endmodule
